// ----- design/fob_pkg.sv -----
// Package for the flow observation batcher: sizes, codes and payload types.
package fob_pkg;

    localparam int NUM_BUCKETS = 4;
    localparam int MAX_BATCH   = 32;
    localparam int BKT_W       = 2;
    localparam int SLOT_W      = $clog2(MAX_BATCH);
    localparam int CNT_W       = $clog2(MAX_BATCH + 1);
    localparam int MEM_DEPTH   = NUM_BUCKETS * MAX_BATCH;
    localparam int MEM_AW      = BKT_W + SLOT_W;
    localparam int CFG_DW      = 16;

    localparam logic [CNT_W-1:0] MAX_BATCH_CNT = CNT_W'(MAX_BATCH);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic CFG_BATCH_LIMIT = 1'b0;
    localparam logic CFG_TIME_LIMIT  = 1'b1;

    localparam logic [5:0]  BATCH_LIMIT_RST = 6'd32;
    localparam logic [15:0] TIME_LIMIT_RST  = 16'd1000;

    typedef struct packed {
        logic               op;
        logic [31:0]        now_ms;
        logic [31:0]        server_ip;
        logic [31:0]        client_ip;
        logic [15:0]        server_port;
        logic [15:0]        client_port;
        logic [7:0]         flag;
        logic signed [7:0]  direction;
        logic [BKT_W-1:0]   flush_bucket;
    } t_obs_req;

    typedef struct packed {
        logic [BKT_W-1:0]   bucket_index;
        logic [31:0]        out_client_ip;
        logic [15:0]        out_client_port;
        logic [31:0]        out_server_ip;
        logic [15:0]        out_server_port;
        logic [7:0]         out_flag;
        logic signed [7:0]  out_direction;
        logic [31:0]        batch_time;
        logic               entry_last;
    } t_batch_result;

    typedef struct packed {
        logic [31:0]        server_ip;
        logic [31:0]        client_ip;
        logic [15:0]        server_port;
        logic [15:0]        client_port;
        logic [7:0]         flag;
        logic signed [7:0]  direction;
    } t_entry;

    typedef struct packed {
        logic [5:0]         batch_limit;
        logic [15:0]        time_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               is_flush;
        logic [BKT_W-1:0]   bucket;
        logic [31:0]        now_ms;
    } t_bkt_req;

    typedef struct packed {
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_slot;
        logic               emit;
        logic [CNT_W-1:0]   emit_cnt;
    } t_bkt_resp;

endpackage

// ----- design/fob_bucket_ctrl.sv -----
// Per-bucket entry counts and batch start times, with the emit decision.
module fob_bucket_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fob_pkg::t_cfg     i_cfg,
    input  fob_pkg::t_bkt_req i_req,
    output fob_pkg::t_bkt_resp o_resp
);
    import fob_pkg::*;

    logic [CNT_W-1:0] r_count [NUM_BUCKETS];
    logic [31:0]      r_start [NUM_BUCKETS];

    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      n_start;
    logic [CNT_W-1:0] eff_limit;
    logic [31:0]      age;
    logic             has_room;
    logic             add_emit;

    always_comb begin
        cur_cnt   = r_count[i_req.bucket];
        has_room  = cur_cnt < MAX_BATCH_CNT;
        n_count   = has_room ? cur_cnt + CNT_W'(1) : cur_cnt;
        n_start   = (r_start[i_req.bucket] == 32'd0) ? i_req.now_ms : r_start[i_req.bucket];
        age       = i_req.now_ms - n_start;
        eff_limit = ({1'b0, i_cfg.batch_limit} > 7'(MAX_BATCH)) ? MAX_BATCH_CNT
                                                                : CNT_W'(i_cfg.batch_limit);
        add_emit  = (n_count >= eff_limit) || (age >= {16'd0, i_cfg.time_limit_ms});

        o_resp.wr_en    = i_req.valid && !i_req.is_flush && has_room;
        o_resp.wr_slot  = cur_cnt[SLOT_W-1:0];
        o_resp.emit     = i_req.is_flush ? (cur_cnt != '0) : add_emit;
        o_resp.emit_cnt = i_req.is_flush ? cur_cnt : n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_count[b] <= '0;
                r_start[b] <= '0;
            end
        end else if (i_req.valid) begin
            if (o_resp.emit) begin
                r_count[i_req.bucket] <= '0;
                r_start[i_req.bucket] <= i_req.now_ms;
            end else if (!i_req.is_flush) begin
                r_count[i_req.bucket] <= n_count;
                r_start[i_req.bucket] <= n_start;
            end
        end
    end

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && o_resp.emit |-> o_resp.emit_cnt != '0)
        else $error("emit with empty batch");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && o_resp.emit |=> r_count[$past(i_req.bucket)] == '0)
        else $error("count not cleared after emit");

    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && !i_req.is_flush && !o_resp.emit |=>
        r_count[$past(i_req.bucket)] == $past(cur_cnt) + CNT_W'(1))
        else $error("append did not advance count");

    a_no_write_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp.wr_en |-> i_req.valid && !i_req.is_flush)
        else $error("entry write from flush request");

endmodule

// ----- design/flow_observation_batcher_unit.sv -----
// Top level of the flow observation batcher: entry memory and emit sequencer.
//
// Usage: a request is taken at a clock edge with i_start high and o_busy low.
// An add request (op = add) stores the observation in bucket client_port mod 4.
// A flush request names a bucket to empty. When a batch is emitted (count or
// age limit reached, or flush of a non-empty bucket), the block stays busy while
// the entries of the batch (1 to 32 of them) are read from the entry memory
// through its single read port, one per cycle; each result shows on o_result
// for one cycle with o_strobe high, starting once the state has entered emit and
// the memory read has been registered, the final one with entry_last set.
// Results cannot be held off; the receiver must take each strobe.
// Configuration: i_cfg_we with i_cfg_index 0 (batch limit) or 1 (time limit in
// ms), to be written only while the block is idle; this binds the user, and the
// block itself does not enforce it. Reset clears all counts and start times and
// sets the limits to 32 entries and 1000 ms; it needs no memory sweep.
module flow_observation_batcher_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  fob_pkg::t_obs_req                 i_req,
    output logic                              o_strobe,
    output fob_pkg::t_batch_result            o_result,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [fob_pkg::CFG_DW-1:0]        i_cfg_wdata
);
    import fob_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state             r_state;
    t_cfg               r_cfg;
    logic [SLOT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]   r_emit_cnt;
    logic [BKT_W-1:0]   r_emit_bkt;
    logic [31:0]        r_emit_time;
    logic               r_out_vld;
    logic               r_out_last;
    t_entry             r_rd_data;

    t_entry             mem [MEM_DEPTH];

    t_bkt_req           bkt_req;
    t_bkt_resp          bkt_resp;
    t_entry             wr_entry;
    logic               n_rd_last;

    assign o_busy = (r_state == S_EMIT);

    always_comb begin
        bkt_req.valid    = i_start && !o_busy;
        bkt_req.is_flush = (i_req.op == OP_FLUSH);
        // bucket count is a power of two, so the modulo is a mask
        bkt_req.bucket   = bkt_req.is_flush ? i_req.flush_bucket
                                            : i_req.client_port[BKT_W-1:0];
        bkt_req.now_ms   = i_req.now_ms;

        wr_entry.server_ip   = i_req.server_ip;
        wr_entry.client_ip   = i_req.client_ip;
        wr_entry.server_port = i_req.server_port;
        wr_entry.client_port = i_req.client_port;
        wr_entry.flag        = i_req.flag;
        wr_entry.direction   = i_req.direction;

        n_rd_last = ({1'b0, r_rd_idx} == (r_emit_cnt - CNT_W'(1)));
    end

    fob_bucket_ctrl u_bucket_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (bkt_req),
        .o_resp  (bkt_resp)
    );

    always_ff @(posedge i_clk) begin
        if (bkt_resp.wr_en) begin
            mem[{bkt_req.bucket, bkt_resp.wr_slot}] <= wr_entry;
        end
        if (r_state == S_EMIT) begin
            r_rd_data <= mem[{r_emit_bkt, r_rd_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.batch_limit   <= BATCH_LIMIT_RST;
            r_cfg.time_limit_ms <= TIME_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BATCH_LIMIT: r_cfg.batch_limit   <= i_cfg_wdata[5:0];
                CFG_TIME_LIMIT:  r_cfg.time_limit_ms <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_out_vld <= 1'b0;
                    if (bkt_req.valid && bkt_resp.emit) begin
                        r_emit_bkt  <= bkt_req.bucket;
                        r_emit_cnt  <= bkt_resp.emit_cnt;
                        r_emit_time <= bkt_req.now_ms;
                        r_rd_idx    <= '0;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_out_vld  <= 1'b1;
                    r_out_last <= n_rd_last;
                    r_rd_idx   <= r_rd_idx + SLOT_W'(1);
                    if (n_rd_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_out_vld;

    always_comb begin
        o_result.bucket_index    = r_emit_bkt;
        o_result.out_client_ip   = r_rd_data.client_ip;
        o_result.out_client_port = r_rd_data.client_port;
        o_result.out_server_ip   = r_rd_data.server_ip;
        o_result.out_server_port = r_rd_data.server_port;
        o_result.out_flag        = r_rd_data.flag;
        o_result.out_direction   = r_rd_data.direction;
        o_result.batch_time      = r_emit_time;
        o_result.entry_last      = r_out_last;
    end

    a_strobe_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("result without memory read");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.entry_last |-> !o_busy)
        else $error("last entry while still reading");

    a_no_write_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !bkt_resp.wr_en)
        else $error("entry write during emission");

endmodule

// ----- test/flow_observation_batcher_unit_tb.sv -----
// Testbench for flow_observation_batcher_unit: predicts each emitted batch and checks every entry.
module flow_observation_batcher_unit_tb;
    import fob_pkg::*;

    class batch_scoreboard;
        t_entry         bucket_q[NUM_BUCKETS][$];
        logic [31:0]    start_ms[NUM_BUCKETS];
        logic [5:0]     batch_limit;
        logic [15:0]    time_limit_ms;
        t_batch_result  pending_q[$];
        int             errors;

        function new();
            batch_limit   = BATCH_LIMIT_RST;
            time_limit_ms = TIME_LIMIT_RST;
            errors        = 0;
            foreach (start_ms[b]) start_ms[b] = '0;
        endfunction

        function void write_cfg(logic index, logic [CFG_DW-1:0] data);
            if (index == CFG_BATCH_LIMIT) begin
                batch_limit = data[5:0];
            end else begin
                time_limit_ms = data[15:0];
            end
        endfunction

        function void emit_batch(int bkt, logic [31:0] now_ms);
            t_batch_result r;
            int            n;
            n = bucket_q[bkt].size();
            for (int k = 0; k < n; k++) begin
                r.bucket_index    = BKT_W'(bkt);
                r.out_client_ip   = bucket_q[bkt][k].client_ip;
                r.out_client_port = bucket_q[bkt][k].client_port;
                r.out_server_ip   = bucket_q[bkt][k].server_ip;
                r.out_server_port = bucket_q[bkt][k].server_port;
                r.out_flag        = bucket_q[bkt][k].flag;
                r.out_direction   = bucket_q[bkt][k].direction;
                r.batch_time      = now_ms;
                r.entry_last      = (k == n - 1);
                pending_q.push_back(r);
            end
            bucket_q[bkt].delete();
            start_ms[bkt] = now_ms;
        endfunction

        function void note_request(t_obs_req req);
            t_entry      e;
            int          bkt;
            int          eff_limit;
            logic [31:0] age;
            if (req.op == OP_FLUSH) begin
                bkt = int'(req.flush_bucket);
                if (bkt < NUM_BUCKETS && bucket_q[bkt].size() != 0)
                    emit_batch(bkt, req.now_ms);
            end else begin
                bkt       = int'(req.client_port) % NUM_BUCKETS;
                eff_limit = (int'(batch_limit) > MAX_BATCH) ? MAX_BATCH : int'(batch_limit);
                if (bucket_q[bkt].size() < MAX_BATCH) begin
                    e.server_ip   = req.server_ip;
                    e.client_ip   = req.client_ip;
                    e.server_port = req.server_port;
                    e.client_port = req.client_port;
                    e.flag        = req.flag;
                    e.direction   = req.direction;
                    bucket_q[bkt].push_back(e);
                end
                // zero start time means none held
                if (start_ms[bkt] == 0) start_ms[bkt] = req.now_ms;
                age = req.now_ms - start_ms[bkt];
                if (bucket_q[bkt].size() >= eff_limit || age >= {16'd0, time_limit_ms})
                    emit_batch(bkt, req.now_ms);
            end
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(t_batch_result got);
            t_batch_result want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected entry, bucket", 32'(got.bucket_index), '0);
            end else begin
                want = pending_q.pop_front();
                if (got.bucket_index !== want.bucket_index)
                    report_mismatch("bucket_index", 32'(got.bucket_index),
                                    32'(want.bucket_index));
                if (got.out_client_ip !== want.out_client_ip)
                    report_mismatch("out_client_ip", got.out_client_ip, want.out_client_ip);
                if (got.out_client_port !== want.out_client_port)
                    report_mismatch("out_client_port", 32'(got.out_client_port),
                                    32'(want.out_client_port));
                if (got.out_server_ip !== want.out_server_ip)
                    report_mismatch("out_server_ip", got.out_server_ip, want.out_server_ip);
                if (got.out_server_port !== want.out_server_port)
                    report_mismatch("out_server_port", 32'(got.out_server_port),
                                    32'(want.out_server_port));
                if (got.out_flag !== want.out_flag)
                    report_mismatch("out_flag", 32'(got.out_flag), 32'(want.out_flag));
                if (got.out_direction !== want.out_direction)
                    report_mismatch("out_direction", 32'(got.out_direction),
                                    32'(want.out_direction));
                if (got.batch_time !== want.batch_time)
                    report_mismatch("batch_time", got.batch_time, want.batch_time);
                if (got.entry_last !== want.entry_last)
                    report_mismatch("entry_last", 32'(got.entry_last), 32'(want.entry_last));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    t_obs_req            i_req;
    logic                o_strobe;
    t_batch_result       o_result;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CFG_DW-1:0]   i_cfg_wdata;

    batch_scoreboard     sb = new();
    int                  accepted_cnt = 0;
    int                  cycle_cnt = 0;
    logic [31:0]         clk_ms;

    flow_observation_batcher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_result);
            if (i_start && !o_busy) begin
                sb.note_request(i_req);
                accepted_cnt++;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 200000) begin
                $display("flow_observation_batcher_unit verification failed");
                $finish;
            end
        end
    end

    function automatic t_obs_req add_req(logic [31:0] now_ms, logic [31:0] sip,
                                         logic [31:0] cip, logic [15:0] sport,
                                         logic [15:0] cport, logic [7:0] flag,
                                         logic [7:0] dir);
        t_obs_req r;
        r.op           = OP_ADD;
        r.now_ms       = now_ms;
        r.server_ip    = sip;
        r.client_ip    = cip;
        r.server_port  = sport;
        r.client_port  = cport;
        r.flag         = flag;
        r.direction    = dir;
        r.flush_bucket = cport[1:0];
        return r;
    endfunction

    function automatic t_obs_req flush_req(logic [31:0] now_ms, logic [BKT_W-1:0] bkt);
        t_obs_req r;
        r              = add_req(now_ms, '0, '0, '0, '0, '0, '0);
        r.op           = OP_FLUSH;
        r.flush_bucket = bkt;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(t_obs_req req, int idle_pct);
        int target;
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_req   = req;
        target  = accepted_cnt + 1;
        do @(negedge i_clk); while (accepted_cnt < target);
    endtask

    task automatic settle();
        i_start = 1'b0;
        do @(negedge i_clk); while (sb.pending_q.size() != 0 || o_busy);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic index, logic [CFG_DW-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.write_cfg(index, data);
    endtask

    task automatic run_phase(int n_items, int idle_pct, int tstep, int hot_bkt,
                             int hot_pct, int flush_pct, int jump_pct);
        t_obs_req req;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < jump_pct) clk_ms = $urandom;
            else clk_ms = clk_ms + $urandom_range(tstep);
            req.op           = ($urandom_range(99) < flush_pct) ? OP_FLUSH : OP_ADD;
            req.now_ms       = clk_ms;
            req.server_ip    = $urandom;
            req.client_ip    = $urandom;
            req.server_port  = 16'($urandom);
            req.client_port  = 16'($urandom);
            req.flag         = 8'($urandom);
            req.direction    = 8'($urandom);
            req.flush_bucket = BKT_W'($urandom);
            if ($urandom_range(99) < hot_pct) req.client_port[1:0] = BKT_W'(hot_bkt);
            send_req(req, idle_pct);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_BATCH_LIMIT;
        i_cfg_wdata = '0;
        clk_ms      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // add at time zero keeps start unset
        send_req(add_req(32'd0, '0, '0, '0, 16'h0000, '0, '0), 0);
        send_req(add_req(32'd5, '1, '1, 16'hFFFF, 16'hFFFC, 8'hFF, 8'hFF), 0);
        send_req(flush_req(32'd7, 2'd0), 0);
        send_req(flush_req(32'd8, 2'd0), 0);
        // age just under, then at, the time limit
        send_req(add_req(32'd100, 32'h0A000001, 32'hC0A80001, 16'd80, 16'h0003,
                         8'h12, 8'h7F), 0);
        send_req(add_req(32'd1099, 32'h0A000002, 32'hC0A80002, 16'd443, 16'h0007,
                         8'h02, 8'h80), 0);
        send_req(add_req(32'd1100, 32'h0A000003, 32'hC0A80003, 16'd22, 16'h000B,
                         8'h10, 8'h01), 0);
        // age across the time wrap
        send_req(add_req(32'hFFFFFFFF, 32'h01020304, 32'h05060708, 16'd53, 16'h0001,
                         8'h18, 8'h00), 0);
        send_req(add_req(32'h000003E7, 32'h11223344, 32'h55667788, 16'd8080, 16'h0005,
                         8'h11, 8'hFE), 0);

        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd1);
        send_req(add_req(32'd2000, 32'hDEADBEEF, 32'hCAFEF00D, 16'd1, 16'h0002,
                         8'h04, 8'h7F), 0);
        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd0);
        send_req(add_req(32'd2001, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h0006,
                         8'h80, 8'h80), 0);
        // limit lowered below a partly filled batch
        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd32);
        for (int i = 0; i < 3; i++)
            send_req(add_req(32'd2002 + i, $urandom, $urandom, 16'($urandom),
                             16'h000A + 16'(4 * i), 8'($urandom), 8'($urandom)), 0);
        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd2);
        send_req(add_req(32'd2010, $urandom, $urandom, 16'($urandom), 16'h0022,
                         8'($urandom), 8'($urandom)), 0);
        settle();
        cfg_write(CFG_TIME_LIMIT, 16'd0);
        send_req(add_req(32'd3000, $urandom, $urandom, 16'($urandom), 16'h0009,
                         8'($urandom), 8'($urandom)), 0);

        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd4);
        cfg_write(CFG_TIME_LIMIT, 16'd1000);
        clk_ms = 32'd4000;
        run_phase(20, 0, 300, 0, 0, 10, 3);

        // limit above capacity: one bucket fills to the full store
        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd63);
        cfg_write(CFG_TIME_LIMIT, 16'd65535);
        run_phase(40, 82, 3, 1, 95, 0, 0);

        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd1);
        cfg_write(CFG_TIME_LIMIT, 16'd500);
        run_phase(12, 82, 100, 0, 0, 10, 3);

        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd8);
        cfg_write(CFG_TIME_LIMIT, 16'd200);
        run_phase(20, 34, 60, 2, 40, 10, 3);

        settle();
        cfg_write(CFG_BATCH_LIMIT, 16'd32);
        cfg_write(CFG_TIME_LIMIT, 16'd1);
        run_phase(10, 0, 1, 3, 50, 10, 3);

        for (int b = 0; b < NUM_BUCKETS; b++)
            send_req(flush_req(clk_ms, BKT_W'(b)), 34);

        settle();
        if (sb.errors == 0) begin
            $display("flow_observation_batcher_unit verification clean");
        end else begin
            $display("flow_observation_batcher_unit verification failed");
        end
        $finish;
    end

endmodule
